### sv/wsd_pkg.sv
// Package for the WebSocket frame deframer.
// Holds length constants, header codes, phase and result types.
// No dependencies.
package wsd_pkg;

    localparam int LengthBits = 64;
    localparam int AccBits    = 64;

    localparam logic [AccBits-1:0] LEN_MASK = {AccBits{1'b1}} >> (AccBits - LengthBits);

    localparam logic [7:0] FIN_TEXT   = 8'h81;
    localparam logic [7:0] LEN_CODE16 = 8'd126;
    localparam logic [7:0] LEN_CODE64 = 8'd127;
    localparam logic [3:0] EXT_BYTES16 = 4'd2;
    localparam logic [3:0] EXT_BYTES64 = 4'd8;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_EXTLEN,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_EMPTY,
        KIND_ERROR
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_TYPE,
        ERR_MASK
    } t_err;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] payload_byte;
        logic       last;
        t_err       error_code;
    } t_result;

endpackage

### sv/wsd_parser.sv
// Header parser and payload counter of the WebSocket frame deframer.
// Consumes one byte per enabled cycle and gives at most one result.
// Depends on wsd_pkg.
module wsd_parser
    import wsd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_byte,
    output t_result       o_res
);

    t_phase                r_phase, n_phase;
    logic [3:0]            r_ext_left, n_ext_left;
    logic [AccBits-1:0]    r_acc, n_acc;
    logic [LengthBits-1:0] r_left, n_left;
    logic                  r_halted, n_halted;

    logic [AccBits-1:0]    acc_shift;
    logic                  acc_sat;

    assign acc_shift = {r_acc[AccBits-9:0], i_byte};
    assign acc_sat   = (acc_shift & ~LEN_MASK) != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FIRST;
            r_ext_left <= '0;
            r_acc      <= '0;
            r_left     <= '0;
            r_halted   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_ext_left <= n_ext_left;
            r_acc      <= n_acc;
            r_left     <= n_left;
            r_halted   <= n_halted;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_ext_left = r_ext_left;
        n_acc      = r_acc;
        n_left     = r_left;
        n_halted   = r_halted;
        o_res      = '{valid: 1'b0, kind: KIND_DATA, payload_byte: 8'h00,
                       last: 1'b0, error_code: ERR_NONE};

        if (i_step && !r_halted) begin
            unique case (r_phase)
                PH_FIRST: begin
                    if (i_byte != FIN_TEXT) begin
                        n_halted         = 1'b1;
                        o_res.valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_TYPE;
                    end else begin
                        n_phase = PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    priority if (i_byte[7]) begin
                        n_halted         = 1'b1;
                        o_res.valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_MASK;
                    end else if (i_byte == LEN_CODE16 || i_byte == LEN_CODE64) begin
                        n_ext_left = (i_byte == LEN_CODE16) ? EXT_BYTES16 : EXT_BYTES64;
                        n_acc      = '0;
                        n_phase    = PH_EXTLEN;
                    end else if (i_byte == 8'h00) begin
                        n_phase     = PH_FIRST;
                        o_res.valid = 1'b1;
                        o_res.kind  = KIND_EMPTY;
                        o_res.last  = 1'b1;
                    end else begin
                        n_left  = LengthBits'(i_byte);
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_EXTLEN: begin
                    n_acc      = acc_shift;
                    n_ext_left = r_ext_left - 4'd1;
                    if (r_ext_left == 4'd1) begin
                        n_acc = '0;
                        if (acc_shift == '0) begin
                            n_phase     = PH_FIRST;
                            o_res.valid = 1'b1;
                            o_res.kind  = KIND_EMPTY;
                            o_res.last  = 1'b1;
                        end else begin
                            n_left  = acc_sat ? LEN_MASK[LengthBits-1:0]
                                              : acc_shift[LengthBits-1:0];
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_left             = (r_left == '0) ? '0 : r_left - LengthBits'(1);
                    o_res.valid        = 1'b1;
                    o_res.kind         = KIND_DATA;
                    o_res.payload_byte = i_byte;
                    o_res.last         = (r_left <= LengthBits'(1));
                    if (o_res.last) begin
                        n_phase = PH_FIRST;
                    end
                end
                default: begin
                    n_phase = PH_FIRST;
                end
            endcase
        end
    end

endmodule

### sv/websocket_frame_deframer.sv
// WebSocket frame deframer, receive side, unmasked final text frames only.
// Input register holds an accepted byte; output register takes its parser result.
// Throughput: one byte per cycle; a stalled full output holds parser and input register.
// Reset: synchronous, active low; parser returns to the first header byte and
// clears the halt flag; both pipeline registers are emptied.
// Depends on wsd_pkg and wsd_parser.
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_payload_byte,
    output logic       o_last,
    output logic [1:0] o_error_code
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_result    r_out;
    t_result    res;
    logic       advance;

    assign advance = !r_out.valid || !i_stall;
    assign o_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    wsd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (r_in_valid && advance),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (advance) begin
            r_out.valid <= r_in_valid && res.valid;
        end
        if (advance && r_in_valid && res.valid) begin
            r_out.kind         <= res.kind;
            r_out.payload_byte <= res.payload_byte;
            r_out.last         <= res.last;
            r_out.error_code   <= res.error_code;
        end
    end

    assign o_valid        = r_out.valid;
    assign o_kind         = r_out.kind;
    assign o_payload_byte = r_out.payload_byte;
    assign o_last         = r_out.last;
    assign o_error_code   = r_out.error_code;

    // nothing follows a delivered error until reset
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_ERROR && !i_stall |=> !o_valid)
        else $error("result after error request");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_ERROR |-> !o_last && o_error_code != ERR_NONE)
        else $error("malformed error request");

    a_nondata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_DATA |-> o_payload_byte == 8'h00)
        else $error("payload byte set on non-data request");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_EMPTY |-> o_last && o_error_code == ERR_NONE)
        else $error("empty message without last mark");

endmodule

### sim/wsd_deframe_checker.sv
// Checker for the WebSocket frame deframer: watches both channels, predicts each result
// from the accepted request bytes and compares in order. Reports failures and the number
// of results still due. Depends on wsd_pkg.
module wsd_deframe_checker
    import wsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_payload_byte,
    input  logic       i_last,
    input  logic [1:0] i_error_code,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_phase      hdr_phase;
    logic [3:0]  ext_left;
    logic [63:0] len_acc;
    logic [63:0] bytes_left;
    logic        halted;
    t_result     due_results[$];
    int          fail_cnt = 0;

    function automatic t_result raise_error(input t_err code);
        t_result r;
        r            = '0;
        halted       = 1'b1;
        r.valid      = 1'b1;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    // Header complete: empty message or start of payload
    function automatic t_result header_done(input logic [63:0] len);
        t_result     r;
        logic [63:0] n;
        r        = '0;
        n        = (len > LEN_MASK) ? LEN_MASK : len;
        len_acc  = '0;
        ext_left = '0;
        if (n == 0) begin
            hdr_phase = PH_FIRST;
            r.valid   = 1'b1;
            r.kind    = KIND_EMPTY;
            r.last    = 1'b1;
        end else begin
            bytes_left = n;
            hdr_phase  = PH_PAYLOAD;
        end
        return r;
    endfunction

    function automatic t_result deframe_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        if (halted)
            return r;
        case (hdr_phase)
            PH_FIRST: begin
                if (b != FIN_TEXT)
                    r = raise_error(ERR_TYPE);
                else
                    hdr_phase = PH_SECOND;
            end
            PH_SECOND: begin
                if (b[7]) begin
                    r = raise_error(ERR_MASK);
                end else if (b == LEN_CODE16 || b == LEN_CODE64) begin
                    ext_left  = (b == LEN_CODE16) ? EXT_BYTES16 : EXT_BYTES64;
                    len_acc   = '0;
                    hdr_phase = PH_EXTLEN;
                end else begin
                    r = header_done({56'd0, b});
                end
            end
            PH_EXTLEN: begin
                len_acc  = {len_acc[55:0], b};
                ext_left = ext_left - 4'd1;
                if (ext_left == 0)
                    r = header_done(len_acc);
            end
            PH_PAYLOAD: begin
                bytes_left     = (bytes_left == 0) ? '0 : bytes_left - 64'd1;
                r.valid        = 1'b1;
                r.kind         = KIND_DATA;
                r.payload_byte = b;
                r.last         = (bytes_left == 0);
                if (r.last)
                    hdr_phase = PH_FIRST;
            end
            default: hdr_phase = PH_FIRST;
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result r;
        if (!i_rst_n) begin
            hdr_phase  = PH_FIRST;
            ext_left   = '0;
            len_acc    = '0;
            bytes_left = '0;
            halted     = 1'b0;
            due_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                r = deframe_byte(i_rx_byte);
                if (r.valid)
                    due_results.push_back(r);
            end
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result: kind %0d byte %0d last %0d error_code %0d",
                           i_kind, i_payload_byte, i_last, i_error_code);
                    fail_cnt++;
                end else begin
                    r = due_results.pop_front();
                    check_field("kind", r.kind, i_kind);
                    check_field("payload_byte", r.payload_byte, i_payload_byte);
                    check_field("last", r.last, i_last);
                    check_field("error_code", r.error_code, i_error_code);
                end
            end
        end
        o_pending    <= due_results.size();
        o_fail_count <= fail_cnt;
    end

endmodule

### sim/websocket_frame_deframer_tb.sv
// Testbench top for the WebSocket frame deframer: clock, reset, byte stream stimulus,
// random gaps and stalls, watchdog and verdict. Depends on wsd_pkg,
// websocket_frame_deframer and wsd_deframe_checker.
module websocket_frame_deframer_tb;
    import wsd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit  = 2000;
    localparam int ByteTarget = 1150;

    typedef enum int {ENC_SHORT, ENC_EXT16, ENC_EXT64} t_len_enc;
    typedef enum int {END_BAD_TYPE, END_MASKED, END_HUGE_LEN} t_ending;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       rx_valid  = 1'b0;
    logic [7:0] rx_byte   = '0;
    logic       rx_stall;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic [1:0] res_kind;
    logic [7:0] res_byte;
    logic       res_last;
    logic [1:0] res_err;
    int         fail_count;
    int         pending;
    bit         calm        = 1'b0;
    int         sent        = 0;
    int         idle_cycles = 0;
    int         stall_run   = 0;

    websocket_frame_deframer u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (rx_valid),
        .o_stall        (rx_stall),
        .i_rx_byte      (rx_byte),
        .o_valid        (res_valid),
        .i_stall        (res_stall),
        .o_kind         (res_kind),
        .o_payload_byte (res_byte),
        .o_last         (res_last),
        .o_error_code   (res_err)
    );

    wsd_deframe_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (rx_valid),
        .i_in_stall     (rx_stall),
        .i_rx_byte      (rx_byte),
        .i_out_valid    (res_valid),
        .i_out_stall    (res_stall),
        .i_kind         (res_kind),
        .i_payload_byte (res_byte),
        .i_last         (res_last),
        .i_error_code   (res_err),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] pick_len(input t_len_enc enc);
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return 0;
        if (r < 65)
            return $urandom_range(1, 6);
        if (r < 88)
            return $urandom_range(7, 40);
        if (r < 96)
            return (enc == ENC_SHORT) ? $urandom_range(100, 125) : $urandom_range(126, 260);
        return (enc == ENC_SHORT) ? 125 : $urandom_range(300, 520);
    endfunction

    always @(negedge clk) begin
        int g;
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else begin
            g = pick_gap();
            res_stall <= (g != 0);
            stall_run <= (g != 0) ? g - 1 : $urandom_range(0, 6);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("websocket_frame_deframer_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_header(input logic [63:0] len, input t_len_enc enc);
        send_byte(FIN_TEXT);
        case (enc)
            ENC_SHORT: send_byte({1'b0, len[6:0]});
            ENC_EXT16: begin
                send_byte(LEN_CODE16);
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default: begin
                send_byte(LEN_CODE64);
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8*i +: 8]);
            end
        endcase
    endtask

    task automatic send_frame(input logic [63:0] len, input t_len_enc enc);
        send_header(len, enc);
        repeat (len)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // Hold the request side until every predicted result has been taken
    task automatic drain();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial begin
        t_len_enc    enc;
        t_ending     ending;
        logic [7:0]  b;
        int          r;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty, single extreme bytes, empty 16-bit, non-minimal 64-bit length
        send_frame(0, ENC_SHORT);
        send_header(1, ENC_SHORT);
        send_byte(8'h00);
        send_header(1, ENC_SHORT);
        send_byte(8'hFF);
        send_frame(0, ENC_EXT16);
        send_header(2, ENC_EXT64);
        send_byte(8'hA5);
        send_byte(8'h5A);
        drain();

        while (sent < ByteTarget) begin
            r    = $urandom_range(99);
            enc  = (r < 60) ? ENC_SHORT : (r < 85) ? ENC_EXT16 : ENC_EXT64;
            calm = ($urandom_range(9) < 2);
            send_frame(pick_len(enc), enc);
            if ($urandom_range(19) == 0)
                drain();
        end
        calm = 1'b0;

        // only one halting event fits in a run with a single reset
        ending = t_ending'($urandom_range(2));
        case (ending)
            END_BAD_TYPE: begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == FIN_TEXT);
                send_byte(b);
            end
            END_MASKED: begin
                send_byte(FIN_TEXT);
                send_byte(8'h80 | 8'($urandom_range(0, 127)));
            end
            default: send_header({1'b1, 31'($urandom), 32'($urandom)}, ENC_EXT64);
        endcase
        send_byte(FIN_TEXT);
        send_byte(8'h00);
        repeat (24)
            send_byte(8'($urandom_range(0, 255)));

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("websocket_frame_deframer_tb: done, clean");
        else
            $display("websocket_frame_deframer_tb: done, errors");
        $finish;
    end

endmodule
